/* rtl/core/assert_macros.svh */
// Assertion macros used by the sine/cosine generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* rtl/core/sct_pkg.sv */
// Shared constants and types of the folded sine/cosine generator.
package sct_pkg;

	localparam int ANGLE_FRAC_BITS_DEF  = 29;
	localparam int RESULT_FRAC_BITS_DEF = 30;
	localparam int COEF_FRAC_BITS_DEF   = 34;

	// integer bits above the fraction for x, x^2 and partial sums
	localparam int GUARD_BITS = 2;
	// register stages in one multiply-add unit
	localparam int MUL_LAT    = 3;
	// Horner steps: sine 1/17! .. 1/1!, cosine 1/20! .. 1/0!
	localparam int SIN_CELLS  = 9;
	localparam int COS_CELLS  = 11;

	// pi * 2^61, rounded
	localparam logic [63:0] PI_Q61 = 64'h6487ED5110B4611A;

	localparam int FACT_W = 80;
	localparam int FACT_N = 23;
	localparam logic [FACT_W-1:0] FACT [0:FACT_N-1] = '{
		80'd1,
		80'd1,
		80'd2,
		80'd6,
		80'd24,
		80'd120,
		80'd720,
		80'd5040,
		80'd40320,
		80'd362880,
		80'd3628800,
		80'd39916800,
		80'd479001600,
		80'd6227020800,
		80'd87178291200,
		80'd1307674368000,
		80'd20922789888000,
		80'd355687428096000,
		80'd6402373705728000,
		80'd121645100408832000,
		80'd2432902008176640000,
		80'd51090942171709440000,
		80'd1124000727777607680000
	};

	typedef struct packed {
		logic vld;
		logic sneg;
		logic cneg;
	} sct_flags_t;

endpackage

/* rtl/core/sct_mul.sv */
// Three-stage multiply-add: addend + sign * round(|a| * |b| / 2^F), split partial products.
module sct_mul #(
	parameter int COEF_FRAC_BITS = sct_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                                              clk,
	input  logic                                              en,
	input  logic        [COEF_FRAC_BITS+sct_pkg::GUARD_BITS-1:0] a_mag,
	input  logic                                              a_neg,
	input  logic signed [COEF_FRAC_BITS+sct_pkg::GUARD_BITS:0]   b,
	input  logic signed [COEF_FRAC_BITS+sct_pkg::GUARD_BITS:0]   addend,
	output logic signed [COEF_FRAC_BITS+sct_pkg::GUARD_BITS:0]   res
);

	localparam int F  = COEF_FRAC_BITS;
	localparam int W  = F + sct_pkg::GUARD_BITS;
	localparam int H  = (W + 1) / 2;
	localparam int L  = W - H;
	localparam int PW = 2 * W;
	localparam int SW = W + 1;
	localparam logic [PW-1:0] RND = PW'(1) << (F - 1);

	logic [W:0]   b_abs_c;
	logic [W-1:0] b_mag_c;
	logic         neg_c;

	logic [2*H-1:0] pll_s1;
	logic [H+L-1:0] plh_s1;
	logic [H+L-1:0] phl_s1;
	logic [2*L-1:0] phh_s1;
	logic           neg_s1;
	logic [W:0]     add_s1;

	logic [PW-1:0]  prod_c;
	logic [W-1:0]   mag_s2;
	logic           neg_s2;
	logic [W:0]     add_s2;

	logic signed [W:0] res_s3;

	assign b_abs_c = b[W] ? SW'(-b) : SW'(b);
	assign b_mag_c = b_abs_c[W-1:0];
	assign neg_c   = a_neg ^ b[W];

	always_ff @(posedge clk) begin
		if (en) begin
			pll_s1 <= a_mag[H-1:0] * b_mag_c[H-1:0];
			plh_s1 <= a_mag[H-1:0] * b_mag_c[W-1:H];
			phl_s1 <= a_mag[W-1:H] * b_mag_c[H-1:0];
			phh_s1 <= a_mag[W-1:H] * b_mag_c[W-1:H];
			neg_s1 <= neg_c;
			add_s1 <= addend;
		end
	end

	// magnitude rounded half away from zero, since sign is applied afterwards
	assign prod_c = PW'(pll_s1) + (PW'(plh_s1) << H) + (PW'(phl_s1) << H)
		+ (PW'(phh_s1) << (2 * H)) + RND;

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s2 <= prod_c[F +: W];
			neg_s2 <= neg_s1;
			add_s2 <= add_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (neg_s2) begin
				res_s3 <= $signed(add_s2) - $signed({1'b0, mag_s2});
			end else begin
				res_s3 <= $signed(add_s2) + $signed({1'b0, mag_s2});
			end
		end
	end

	assign res = res_s3;

endmodule

/* rtl/core/sct_cell.sv */
// One Horner step: acc_out = COEF - x^2 * acc_in, with x^2 handed on to the next step.
module sct_cell #(
	parameter int COEF_FRAC_BITS = sct_pkg::COEF_FRAC_BITS_DEF,
	parameter logic [COEF_FRAC_BITS+sct_pkg::GUARD_BITS-1:0] COEF = '0
) (
	input  logic                                              clk,
	input  logic                                              en,
	input  logic        [COEF_FRAC_BITS+sct_pkg::GUARD_BITS-1:0] m2_in,
	input  logic signed [COEF_FRAC_BITS+sct_pkg::GUARD_BITS:0]   acc_in,
	output logic        [COEF_FRAC_BITS+sct_pkg::GUARD_BITS-1:0] m2_out,
	output logic signed [COEF_FRAC_BITS+sct_pkg::GUARD_BITS:0]   acc_out
);

	localparam int W = COEF_FRAC_BITS + sct_pkg::GUARD_BITS;

	logic [W-1:0] m2_s1;
	logic [W-1:0] m2_s2;
	logic [W-1:0] m2_s3;

	// multiplicand is -x^2: magnitude m2 with a negative sign
	sct_mul #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_mul (
		.clk    (clk),
		.en     (en),
		.a_mag  (m2_in),
		.a_neg  (1'b1),
		.b      (acc_in),
		.addend ($signed({1'b0, COEF})),
		.res    (acc_out)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			m2_s1 <= m2_in;
			m2_s2 <= m2_s1;
			m2_s3 <= m2_s2;
		end
	end

	assign m2_out = m2_s3;

endmodule

/* rtl/core/sine_cosine_taylor_folded.sv */
// Folded Taylor-series sine/cosine generator, one angle in, one sine/cosine pair out.
//
//  channel   dir  payload                                   handshake
//  s_axis    in   tdata[31:0] angle, Q2.29                  s_tvalid / s_tready
//  m_axis    out  tdata[31:0] sine, tdata[63:32] cosine     m_tvalid / m_tready
//
// One angle per cycle while s_tready is high.
// The pipeline depth is set by the cosine row: 11 Horner cells, plus the
// magnitude, fold, square and format stages. arst_n clears all valid flags; no fill pass.
// An output register and a one-item skid stage follow the pipeline; s_tready
// drops only once the skid stage holds an item, and the whole pipeline then holds.
`include "assert_macros.svh"

module sine_cosine_taylor_folded #(
	parameter int ANGLE_FRAC_BITS  = sct_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int RESULT_FRAC_BITS = sct_pkg::RESULT_FRAC_BITS_DEF,
	parameter int COEF_FRAC_BITS   = sct_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] angle
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata    // [31:0] sine_value, [63:32] cosine_value
);

	localparam int AF   = ANGLE_FRAC_BITS;
	localparam int RF   = RESULT_FRAC_BITS;
	localparam int F    = COEF_FRAC_BITS;
	localparam int W    = F + sct_pkg::GUARD_BITS;
	localparam int NSIN = sct_pkg::SIN_CELLS;
	localparam int NCOS = sct_pkg::COS_CELLS;
	localparam int LAT  = sct_pkg::MUL_LAT;
	localparam int FW   = sct_pkg::FACT_W;

	// angle datapath width
	localparam int AW = (AF + 3 > 33) ? AF + 3 : 33;
	localparam int PI_SH = 61 - AF;
	localparam logic [63:0] PI_FIX = (sct_pkg::PI_Q61 + (64'd1 << (PI_SH - 1))) >> PI_SH;
	localparam logic [AW-1:0] PI_U = PI_FIX[AW-1:0];

	// angle to coefficient format
	localparam int XCW    = AW + F + 1;
	localparam int XSH_L  = (F >= AF) ? F - AF : 0;
	localparam int XSH_R  = (F >= AF) ? 0 : AF - F;
	localparam int XSH_R1 = (XSH_R > 0) ? XSH_R - 1 : 0;
	localparam logic [XCW-1:0] XRND = (XSH_R > 0) ? (XCW'(1) << XSH_R1) : '0;

	// coefficient format to result format
	localparam int UW    = ((RF > F) ? RF : F) + 2;
	localparam int OW    = (UW > 32) ? UW : 32;
	localparam int SH_L  = (RF >= F) ? RF - F : 0;
	localparam int SH_R  = (RF >= F) ? 0 : F - RF;
	localparam int SH_R1 = (SH_R > 0) ? SH_R - 1 : 0;
	localparam logic [UW-1:0] RND_R = (SH_R > 0) ? (UW'(1) << SH_R1) : '0;
	localparam logic [W-1:0]  ONE   = W'(1) << F;

	// Taylor coefficients round(2^F / n!), ties up
	localparam logic [FW-1:0] NUM = FW'(1) << (F + 1);
	localparam logic [FW-1:0] Q_SIN0 = NUM / sct_pkg::FACT[2 * NSIN + 1];
	localparam logic [FW-1:0] Q_COS0 = NUM / sct_pkg::FACT[2 * NCOS];
	localparam logic [W-1:0]  C_SIN0 = W'((Q_SIN0 + FW'(1)) >> 1);
	localparam logic [W-1:0]  C_COS0 = W'((Q_COS0 + FW'(1)) >> 1);

	// alignment of the side data with the rows
	localparam int DL   = LAT + NCOS * LAT;
	localparam int XDL  = LAT + NSIN * LAT;
	localparam int SPAD = (NCOS - NSIN - 1) * LAT;

	function automatic logic [UW-1:0] fmt_mag(input logic signed [W:0] v);
		logic [W-1:0] m;
		if (v[W]) begin
			m = '0;
		end else if (v[W-1:0] > ONE) begin
			m = ONE;
		end else begin
			m = v[W-1:0];
		end
		return ((UW'(m) << SH_L) + RND_R) >> SH_R;
	endfunction

	function automatic logic [31:0] sign_out(input logic [UW-1:0] u, input logic neg);
		logic [OW-1:0] e;
		e = OW'(u);
		if (neg) begin
			e = -e;
		end
		return e[31:0];
	endfunction

	logic en;

	logic signed [AW-1:0] ang_c;
	logic        [AW-1:0] abs_c;
	logic        [AW-1:0] mag_c;
	logic        [AW-1:0] mag_s1;
	sct_pkg::sct_flags_t  flags_s1;

	logic [AW-1:0] diff_c;
	logic [AW-1:0] xa_c;
	logic          cneg_c;
	logic [W-1:0]  x_c;
	logic [W-1:0]  x_s2;
	sct_pkg::sct_flags_t flags_s2;

	logic signed [W:0] sq_res;
	logic        [W-1:0] m2;

	logic        [W-1:0] cos_m2  [0:NCOS-1];
	logic signed [W:0]   cos_acc [0:NCOS];
	logic        [W-1:0] sin_m2  [0:NSIN-1];
	logic signed [W:0]   sin_acc [0:NSIN];
	logic signed [W:0]   sin_prod;
	logic signed [W:0]   sin_pad_q [0:SPAD-1];

	sct_pkg::sct_flags_t flags_q [0:DL-1];
	logic [W-1:0]        x_q     [0:XDL-1];

	logic [UW-1:0]       sin_u_s39;
	logic [UW-1:0]       cos_u_s39;
	sct_pkg::sct_flags_t flags_s39;
	logic [31:0]         sin_s40;
	logic [31:0]         cos_s40;
	sct_pkg::sct_flags_t flags_s40;

	logic        take_c;
	logic        pop_c;
	logic        out_v_q;
	logic        skid_v_q;
	logic [63:0] out_d_q;
	logic [63:0] skid_d_q;

	assign en       = !skid_v_q;
	assign s_tready = en;

	// stage 1: magnitude with saturation to pi
	assign ang_c = AW'($signed(s_tdata));
	assign abs_c = s_tdata[31] ? AW'(-ang_c) : AW'(ang_c);
	assign mag_c = (abs_c > PI_U) ? PI_U : abs_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_s1 <= '0;
		end else if (en) begin
			flags_s1.vld  <= s_tvalid;
			flags_s1.sneg <= s_tdata[31];
			flags_s1.cneg <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= mag_c;
		end
	end

	// stage 2: fold into [0, pi/2], cosine sign, convert to coefficient format
	assign diff_c = PI_U - mag_s1;
	assign xa_c   = (diff_c < mag_s1) ? diff_c : mag_s1;
	assign cneg_c = ({1'b0, mag_s1} << 1) > {1'b0, PI_U};
	assign x_c    = W'(((XCW'(xa_c) << XSH_L) + XRND) >> XSH_R);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_s2 <= '0;
		end else if (en) begin
			flags_s2.vld  <= flags_s1.vld;
			flags_s2.sneg <= flags_s1.sneg;
			flags_s2.cneg <= cneg_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2 <= x_c;
		end
	end

	// x^2, rounded; its negation is the Horner variable
	sct_mul #(
		.COEF_FRAC_BITS(F)
	) u_square (
		.clk    (clk),
		.en     (en),
		.a_mag  (x_s2),
		.a_neg  (1'b0),
		.b      ($signed({1'b0, x_s2})),
		.addend ('0),
		.res    (sq_res)
	);

	assign m2 = sq_res[W-1:0];

	assign cos_m2[0]  = m2;
	assign cos_acc[0] = $signed({1'b0, C_COS0});
	assign sin_m2[0]  = m2;
	assign sin_acc[0] = $signed({1'b0, C_SIN0});

	for (genvar i = 0; i < NCOS; i++) begin : g_cos
		localparam int K = 2 * (NCOS - 1 - i);
		localparam logic [FW-1:0] QK = NUM / sct_pkg::FACT[K];
		localparam logic [W-1:0]  CK = W'((QK + FW'(1)) >> 1);
		if (i < NCOS - 1) begin : g_mid
			sct_cell #(
				.COEF_FRAC_BITS(F),
				.COEF          (CK)
			) u_cell (
				.clk     (clk),
				.en      (en),
				.m2_in   (cos_m2[i]),
				.acc_in  (cos_acc[i]),
				.m2_out  (cos_m2[i+1]),
				.acc_out (cos_acc[i+1])
			);
		end else begin : g_end
			sct_cell #(
				.COEF_FRAC_BITS(F),
				.COEF          (CK)
			) u_cell (
				.clk     (clk),
				.en      (en),
				.m2_in   (cos_m2[i]),
				.acc_in  (cos_acc[i]),
				.m2_out  (),
				.acc_out (cos_acc[i+1])
			);
		end
	end

	for (genvar i = 0; i < NSIN; i++) begin : g_sin
		localparam int K = 2 * (NSIN - 1 - i) + 1;
		localparam logic [FW-1:0] QK = NUM / sct_pkg::FACT[K];
		localparam logic [W-1:0]  CK = W'((QK + FW'(1)) >> 1);
		if (i < NSIN - 1) begin : g_mid
			sct_cell #(
				.COEF_FRAC_BITS(F),
				.COEF          (CK)
			) u_cell (
				.clk     (clk),
				.en      (en),
				.m2_in   (sin_m2[i]),
				.acc_in  (sin_acc[i]),
				.m2_out  (sin_m2[i+1]),
				.acc_out (sin_acc[i+1])
			);
		end else begin : g_end
			sct_cell #(
				.COEF_FRAC_BITS(F),
				.COEF          (CK)
			) u_cell (
				.clk     (clk),
				.en      (en),
				.m2_in   (sin_m2[i]),
				.acc_in  (sin_acc[i]),
				.m2_out  (),
				.acc_out (sin_acc[i+1])
			);
		end
	end

	// sine = x * series, then padded to line up with the longer cosine row
	sct_mul #(
		.COEF_FRAC_BITS(F)
	) u_sin_x (
		.clk    (clk),
		.en     (en),
		.a_mag  (x_q[XDL-1]),
		.a_neg  (1'b0),
		.b      (sin_acc[NSIN]),
		.addend ('0),
		.res    (sin_prod)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			sin_pad_q[0] <= sin_prod;
			for (int i = 1; i < SPAD; i++) begin
				sin_pad_q[i] <= sin_pad_q[i-1];
			end
			x_q[0] <= x_s2;
			for (int i = 1; i < XDL; i++) begin
				x_q[i] <= x_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DL; i++) begin
				flags_q[i] <= '0;
			end
		end else if (en) begin
			flags_q[0] <= flags_s2;
			for (int i = 1; i < DL; i++) begin
				flags_q[i] <= flags_q[i-1];
			end
		end
	end

	// format: clamp to [0, 1], round to result format, then apply sign
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_s39 <= '0;
			flags_s40 <= '0;
		end else if (en) begin
			flags_s39 <= flags_q[DL-1];
			flags_s40 <= flags_s39;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sin_u_s39 <= fmt_mag(sin_pad_q[SPAD-1]);
			cos_u_s39 <= fmt_mag(cos_acc[NCOS]);
			sin_s40   <= sign_out(sin_u_s39, flags_s39.sneg);
			cos_s40   <= sign_out(cos_u_s39, flags_s39.cneg);
		end
	end

	// output register with one-item skid stage
	assign take_c = flags_s40.vld && en;
	assign pop_c  = out_v_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop_c) begin
				skid_v_q <= 1'b0;
			end
		end else if (pop_c || !out_v_q) begin
			out_v_q <= take_c;
		end else if (take_c) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop_c) begin
				out_d_q <= skid_d_q;
			end
		end else if (pop_c || !out_v_q) begin
			out_d_q <= {cos_s40, sin_s40};
		end else if (take_c) begin
			skid_d_q <= {cos_s40, sin_s40};
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_d_q;

	`ASSERT_NEVER(a_skid_without_out, clk, arst_n, skid_v_q && !out_v_q, "skid full, output empty")
	`ASSERT_IMPL(a_skid_fill_cause, clk, arst_n, $rose(skid_v_q) |-> $past(out_v_q && !m_tready), "skid filled without output stall")
	`ASSERT_IMPL(a_skid_drains, clk, arst_n, skid_v_q && m_tready |=> !skid_v_q && out_v_q, "skid item not moved to output")

endmodule

/* verif/sine_cosine_taylor_folded_tb.sv */
// Testbench for the folded Taylor-series sine/cosine generator: directed and random angles.
module sine_cosine_taylor_folded_tb;

	localparam int AF = sct_pkg::ANGLE_FRAC_BITS_DEF;
	localparam int RF = sct_pkg::RESULT_FRAC_BITS_DEF;
	localparam int CF = sct_pkg::COEF_FRAC_BITS_DEF;

	// pi * 2^61, rounded
	localparam logic [63:0] PI_61 = 64'h6487ED5110B4611A;
	localparam int ANG_PI      = 1686629713;
	localparam int ANG_HALF_PI = 843314856;
	localparam int CYCLE_LIMIT = 300000;
	// idle time at the end, longer than the pipeline including the output register
	localparam int QUIET_CYCLES = 60;

	typedef struct {
		logic [31:0] angle;
		logic [31:0] sine;
		logic [31:0] cosine;
	} sincos_t;

	typedef enum int {RX_OPEN, RX_COIN, RX_SLOW, RX_COMB} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;   // [31:0] angle
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;        // [31:0] sine_value, [63:32] cosine_value

	sincos_t  pending_sincos[$];
	int       mismatch_count = 0;
	int       cycle_count = 0;
	int       burst_left = 0;
	bit       gaps_on = 1'b1;
	rx_mode_t rx_mode = RX_OPEN;
	int       rx_left = 0;

	sine_cosine_taylor_folded dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// signed a*b / 2^CF, magnitude rounded half away from zero
	function automatic longint fx_mul(input longint a, input longint b);
		logic         neg;
		logic [63:0]  ua;
		logic [63:0]  ub;
		logic [127:0] prod;
		logic [62:0]  m;
		neg = (a < 0) != (b < 0);
		ua = (a < 0) ? 64'(-a) : 64'(a);
		ub = (b < 0) ? 64'(-b) : 64'(b);
		prod = {64'd0, ua} * {64'd0, ub};
		prod = prod + (128'd1 << (CF - 1));
		m = prod[CF +: 63];
		return neg ? -longint'({1'b0, m}) : longint'({1'b0, m});
	endfunction

	// round(2^CF / n!), ties up; zero once below half an lsb
	function automatic longint taylor_recip(input int n);
		logic [63:0] num;
		logic [63:0] fact;
		num = 64'd1 << (CF + 1);
		fact = 64'd1;
		for (int i = 2; i <= n; i++) begin
			if (fact > num / 64'(i))
				return 0;
			fact = fact * 64'(i);
		end
		return longint'(((num / fact) + 64'd1) >> 1);
	endfunction

	// clamp magnitude to [0, 1.0] and move to result fraction bits
	function automatic logic [63:0] to_result_mag(input longint v);
		logic [63:0] u;
		int          d;
		d = RF - CF;
		if (v < 0)
			v = 0;
		if (v > (longint'(1) << CF))
			v = longint'(1) << CF;
		u = 64'(v);
		if (d >= 0)
			u = u << d;
		else
			u = (u + (64'd1 << (-d - 1))) >> (-d);
		return u;
	endfunction

	function automatic sincos_t predict_sincos(input logic [31:0] ang);
		sincos_t     r;
		longint      a;
		longint      pq;
		longint      mag;
		longint      xa;
		longint      x;
		longint      mx2;
		longint      one;
		longint      acc;
		longint      s;
		longint      c;
		logic [63:0] sm;
		logic [63:0] cm;
		logic        cneg;
		int          d;
		a = longint'($signed(ang));
		pq = longint'((PI_61 + (64'd1 << (61 - AF - 1))) >> (61 - AF));
		if (a > pq)
			a = pq;
		if (a < -pq)
			a = -pq;
		mag = (a < 0) ? -a : a;
		cneg = (2 * mag) > pq;
		xa = (pq - mag < mag) ? pq - mag : mag;
		d = CF - AF;
		if (d >= 0)
			x = xa << d;
		else
			x = longint'((64'(xa) + (64'd1 << (-d - 1))) >> (-d));
		one = longint'(1) << CF;
		mx2 = -fx_mul(x, x);

		acc = taylor_recip(19);
		for (int k = 17; k >= 3; k -= 2)
			acc = taylor_recip(k) + fx_mul(mx2, acc);
		acc = one + fx_mul(mx2, acc);
		s = fx_mul(x, acc);

		acc = taylor_recip(22);
		for (int k = 20; k >= 2; k -= 2)
			acc = taylor_recip(k) + fx_mul(mx2, acc);
		c = one + fx_mul(mx2, acc);

		sm = to_result_mag(s);
		cm = to_result_mag(c);
		if (a < 0)
			sm = -sm;
		if (cneg)
			cm = -cm;
		r.angle = ang;
		r.sine = sm[31:0];
		r.cosine = cm[31:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] ang,
			input logic [31:0] got, input logic [31:0] want);
		mismatch_count++;
		$display("%s: angle %h got %h want %h", what, ang, got, want);
	endtask

	// predict on accepted angles, compare on accepted results
	always @(posedge clk) begin : sincos_check
		sincos_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				pending_sincos.push_back(predict_sincos(s_tdata));
			if (m_tvalid && m_tready) begin
				if (pending_sincos.size() == 0) begin
					report_mismatch("unexpected result", 32'h0, m_tdata[31:0], 32'h0);
				end else begin
					want = pending_sincos.pop_front();
					if (m_tdata[31:0] !== want.sine)
						report_mismatch("sine", want.angle, m_tdata[31:0], want.sine);
					if (m_tdata[63:32] !== want.cosine)
						report_mismatch("cosine", want.angle, m_tdata[63:32], want.cosine);
				end
			end
		end
	end

	// receiver backpressure, pattern changes every so often
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_left <= $urandom_range(16, 160);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_OPEN: m_tready <= 1'b1;
			RX_COIN: m_tready <= 1'($urandom_range(0, 1));
			RX_SLOW: m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= (cycle_count[2:0] != 3'd0);
		endcase
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("sine_cosine_taylor_folded: mismatch");
			$finish;
		end
	end

	// called right after a rising edge; returns at the edge that takes the item
	task automatic send_angle(input logic [31:0] ang);
		int gap;
		if (burst_left == 0) begin
			gap = 0;
			if (gaps_on && $urandom_range(0, 2) != 0)
				gap = $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		s_tvalid <= 1'b1;
		s_tdata <= ang;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		burst_left--;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_sincos.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic test_directed();
		logic [31:0] vals [$];
		vals = '{32'd0, 32'(ANG_PI), 32'(-ANG_PI), 32'(ANG_HALF_PI),
			32'(ANG_HALF_PI + 1), 32'(-ANG_HALF_PI), 32'(-ANG_HALF_PI - 1),
			32'(ANG_HALF_PI - 1), 32'(ANG_HALF_PI + 2), 32'd1, 32'hFFFF_FFFF,
			32'h7FFF_FFFF, 32'h8000_0000, 32'(ANG_PI + 1), 32'(-ANG_PI - 1),
			32'(ANG_PI - 1), 32'(-ANG_PI + 1), 32'(ANG_HALF_PI / 2),
			32'(-(ANG_HALF_PI / 2)), 32'h0010_0000, 32'h5555_5555, 32'hAAAA_AAAA};
		foreach (vals[i])
			send_angle(vals[i]);
	endtask

	task automatic test_uniform_range(input int count);
		logic [31:0] ang;
		repeat (count) begin
			ang = 32'($urandom_range(0, 2 * unsigned'(ANG_PI))) - 32'(ANG_PI);
			send_angle(ang);
		end
	endtask

	// any 32-bit word, so out-of-range angles saturate
	task automatic test_full_word(input int count);
		repeat (count)
			send_angle($urandom);
	endtask

	// small offsets around zero, +-pi/2 and +-pi
	task automatic test_fold_points(input int count);
		int base;
		int off;
		repeat (count) begin
			case ($urandom_range(0, 4))
				0: base = 0;
				1: base = ANG_HALF_PI;
				2: base = -ANG_HALF_PI;
				3: base = ANG_PI;
				default: base = -ANG_PI;
			endcase
			off = int'($urandom_range(0, 2000)) - 1000;
			send_angle(32'(base + off));
		end
	endtask

	task automatic test_back_to_back(input int count);
		gaps_on = 1'b0;
		test_uniform_range(count);
		gaps_on = 1'b1;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		wait_drained();
		test_uniform_range(300);
		wait_drained();
		test_full_word(100);
		test_fold_points(150);
		wait_drained();
		test_back_to_back(50);
		wait_drained();

		repeat (QUIET_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_sincos.size() == 0)
			$display("sine_cosine_taylor_folded: match");
		else
			$display("sine_cosine_taylor_folded: mismatch");
		$finish;
	end

endmodule
